/* rtl/ham6_pkg.sv */
// Shared types and constants for the HAM6 planar pixel decoder.
`default_nettype none

package ham6_pkg;

    localparam int PIXELS_PER_ITEM = 8;
    localparam int PIX_IDX_W       = $clog2(PIXELS_PER_ITEM);
    localparam int RGB_W           = 12;
    localparam int NIBBLE_W        = 4;
    localparam int PAL_DEPTH       = 16;
    localparam int PAL_IDX_W       = $clog2(PAL_DEPTH);

    localparam logic [RGB_W-1:0] MASK_RGB = 12'hFFF;
    localparam logic [RGB_W-1:0] KEEP_RG  = 12'hFF0;
    localparam logic [RGB_W-1:0] KEEP_GB  = 12'h0FF;
    localparam logic [RGB_W-1:0] KEEP_RB  = 12'hF0F;

    // Item operation codes
    typedef enum logic {
        OP_PALETTE = 1'b0,
        OP_PIXELS  = 1'b1
    } op_t;

    // Per-pixel hold-and-modify control codes
    typedef enum logic [1:0] {
        CTRL_PALETTE = 2'd0,
        CTRL_BLUE    = 2'd1,
        CTRL_RED     = 2'd2,
        CTRL_GREEN   = 2'd3
    } ctrl_t;

    typedef struct packed {
        logic                 op;
        logic [PAL_IDX_W-1:0] palette_index;
        logic [RGB_W-1:0]     palette_color;
        logic                 row_start;
        logic [7:0]           plane_byte_0;
        logic [7:0]           plane_byte_1;
        logic [7:0]           plane_byte_2;
        logic [7:0]           plane_byte_3;
        logic [7:0]           plane_byte_4;
        logic [7:0]           plane_byte_5;
    } item_t;

    typedef struct packed {
        logic [RGB_W-1:0] rgb_color;
        logic             last_pixel;
    } result_t;

endpackage

`default_nettype wire

/* rtl/ham6_item_if.sv */
// Valid/ready channel interfaces for decoder items and pixel results.
`default_nettype none

interface ham6_item_if;
    logic              valid;
    logic              ready;
    ham6_pkg::item_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ham6_result_if;
    logic              valid;
    logic              ready;
    ham6_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/ham6_pix_decode.sv */
// Hold-and-modify decode of one 6-bit pixel against the held colour.
`default_nettype none

module ham6_pix_decode (
    input  var ham6_pkg::ctrl_t                   ctrl,
    input  var logic [ham6_pkg::NIBBLE_W-1:0]     data,
    input  var logic [ham6_pkg::RGB_W-1:0]        held,
    input  var logic [ham6_pkg::RGB_W-1:0]        pal_color,
    output logic [ham6_pkg::RGB_W-1:0]            color
);

    // Pick palette entry or replace one channel of the held colour
    always_comb
    begin
        unique case (ctrl)
            ham6_pkg::CTRL_PALETTE:
                color = pal_color & ham6_pkg::MASK_RGB;
            ham6_pkg::CTRL_BLUE:
                color = (held & ham6_pkg::KEEP_RG) | {8'd0, data};
            ham6_pkg::CTRL_RED:
                color = (held & ham6_pkg::KEEP_GB) | {data, 8'd0};
            ham6_pkg::CTRL_GREEN:
                color = (held & ham6_pkg::KEEP_RB) | {4'd0, data, 4'd0};
            default:
                color = held;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/ham6_planar_pixel_decoder_core.sv */
// Top level of the HAM6 planar pixel decoder: item slot, palette and result register.
//
// Usage:
//   item   (sink)  : one beat is a palette write (op = 0) or six plane bytes (op = 1).
//   result (source): one beat per decoded pixel, rgb_color plus last_pixel.
//   A palette write updates the 16-entry palette on acceptance and yields no beat.
//   A pixel item is latched into an item slot and emits eight beats, leftmost
//   pixel first; last_pixel marks the eighth.
//   The first pixel beat passes through the item slot and then the result register.
//   The next item is accepted in the cycle the eighth pixel is decoded, so
//   pixel items stream without gaps. A palette write is accepted only while
//   the slot is empty or in the cycle the eighth pixel is decoded.
//   A stall on result holds the result register and freezes decoding; the
//   item slot stays full and item.ready stays low until the last pixel moves.
//   Reset clears the held colour to zero and empties the slot and the result
//   register. Palette contents are undefined until written.
`default_nettype none

module ham6_planar_pixel_decoder_core (
    input  var logic       clk,
    input  var logic       rst_n,
    ham6_item_if.sink      item,
    ham6_result_if.source  result
);

    localparam int RGB_W = ham6_pkg::RGB_W;
    localparam int IDX_W = ham6_pkg::PIX_IDX_W;

    ham6_pkg::item_t          item_reg;
    logic                     busy_reg, busy_next;
    logic [IDX_W-1:0]         pix_reg, pix_next;
    logic [RGB_W-1:0]         held_reg, held_next;
    logic [RGB_W-1:0]         palette_reg [ham6_pkg::PAL_DEPTH];
    logic                     out_valid_reg, out_valid_next;
    ham6_pkg::result_t        out_reg;

    logic                     advance;
    logic                     last;
    logic                     accept;
    logic [IDX_W-1:0]         pos;
    logic [ham6_pkg::NIBBLE_W-1:0] data;
    ham6_pkg::ctrl_t          ctrl;
    logic [RGB_W-1:0]         base;
    logic [RGB_W-1:0]         color;

    // Handshake and pixel select
    always_comb
    begin
        advance    = busy_reg && (!out_valid_reg || result.ready);
        last       = (pix_reg == IDX_W'(ham6_pkg::PIXELS_PER_ITEM - 1));
        item.ready = !busy_reg || (advance && last);
        accept     = item.valid && item.ready;
        pos        = IDX_W'(ham6_pkg::PIXELS_PER_ITEM - 1) - pix_reg;
        data       = {item_reg.plane_byte_3[pos], item_reg.plane_byte_2[pos],
                      item_reg.plane_byte_1[pos], item_reg.plane_byte_0[pos]};
        ctrl       = ham6_pkg::ctrl_t'({item_reg.plane_byte_5[pos],
                                        item_reg.plane_byte_4[pos]});
        base       = (pix_reg == '0 && item_reg.row_start)
                     ? (palette_reg[0] & ham6_pkg::MASK_RGB) : held_reg;
    end

    ham6_pix_decode u_decode (
        .ctrl      (ctrl),
        .data      (data),
        .held      (base),
        .pal_color (palette_reg[data]),
        .color     (color)
    );

    // Next-state for slot, pixel counter, held colour and result valid
    always_comb
    begin
        busy_next      = busy_reg;
        pix_next       = pix_reg;
        held_next      = held_reg;
        out_valid_next = out_valid_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            held_next      = color;
            pix_next       = pix_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
                pix_next  = '0;
            end
        end
        if (accept && item.data.op == ham6_pkg::OP_PIXELS)
        begin
            busy_next = 1'b1;
            pix_next  = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pix_reg       <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pix_reg       <= pix_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: item slot, result beat, palette
    always_ff @(posedge clk)
    begin
        if (accept && item.data.op == ham6_pkg::OP_PIXELS)
        begin
            item_reg <= item.data;
        end
        if (accept && item.data.op == ham6_pkg::OP_PALETTE)
        begin
            palette_reg[item.data.palette_index] <=
                item.data.palette_color & ham6_pkg::MASK_RGB;
        end
        if (advance)
        begin
            out_reg.rgb_color  <= color;
            out_reg.last_pixel <= last;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

endmodule

`default_nettype wire
